/* rtl/a2b_pkg.sv */
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants for the length-prefixed to Annex B converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

    // Stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 4;
    localparam int PLEN_W     = 24;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN    = 2'd1;
    localparam logic [1:0] STATUS_BAD_RECORD = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

    // NAL unit types of interest
    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
    localparam logic [4:0] NAL_TYPE_SEI = 5'd6;

    // Record header bytes skipped after the first one
    localparam logic [15:0] REC_HEAD_BYTES = 16'd4;
    // Smallest remainder that can still hold a length field
    localparam logic [PLEN_W-1:0] MIN_NAL_SPAN = 24'd4;

    // Data source for store writes and output bytes
    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_ZERO,
        SEL_ONE,
        SEL_RAM,
        SEL_MARK
    } data_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       count_clr;
        logic       err_clr;
        logic       err_set;
        logic       rec_init;
        logic       smp_init;
        logic       ubl_dec;
        logic       ubl_hi;
        logic       ubl_lo;
        logic       units_load;
        logic       units_dec;
        logic       put;
        data_sel_t  put_sel;
        logic       sbl_dec;
        logic       len_shift;
        logic       len_clr;
        logic       nal_load;
        logic       nal_dec;
        logic       drop_load;
        logic       pidx_clr;
        logic       pidx_inc;
        logic       ram_rd;
        logic       out_load;
        data_sel_t  out_sel;
        logic       out_run_last;
        logic       out_end;
        logic [1:0] out_status;
    } a2b_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       mode;
        logic       last;
        logic       plen_lt4;
        logic       ubl_one;
        logic       ubl_zero;
        logic       units_one;
        logic       byte_units_zero;
        logic       sbl_dec_lt4;
        logic       len_fourth;
        logic       len_bad;
        logic       nal_one;
        logic       type_idr;
        logic       type_sei;
        logic       dropped;
        logic [1:0] err;
        logic       pidx_end;
        logic       out_free;
    } a2b_stat_t;

endpackage

/* rtl/a2b_ram.sv */
// ----------------------------------------------------------------------------
// a2b_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module a2b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/a2b_dp.sv */
// ----------------------------------------------------------------------------
// a2b_dp
// Datapath: item capture, parse counters, parameter store and output register.
// ----------------------------------------------------------------------------
module a2b_dp import a2b_pkg::*; #(
    parameter int PARAM_STORE_BYTES = 56,
    parameter int LENGTH_BITS       = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tuser,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    output logic                  m_tlast,
    input  a2b_cmd_t              cmd,
    output a2b_stat_t             st
);

    localparam int CNT_W  = $clog2(PARAM_STORE_BYTES + 1);
    localparam int ADDR_W = $clog2(PARAM_STORE_BYTES);
    localparam int NAL_W  = (LENGTH_BITS < PLEN_W) ? LENGTH_BITS : PLEN_W;

    // captured item
    logic              mode_reg;
    logic [7:0]        byte_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic              last_reg;

    logic [15:0]       ubl_reg;
    logic [4:0]        units_reg;
    logic [PLEN_W-1:0] sbl_reg;
    logic [NAL_W-1:0]  nal_reg;
    logic [1:0]        lencnt_reg;
    logic [23:0]       shift_reg;
    logic              dropped_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  pidx_reg;
    logic [1:0]        err_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    logic [31:0]       len_word;
    logic [PLEN_W-1:0] sbl_after;
    logic              len_bad;
    logic              full;
    logic              wr_en;
    logic [7:0]        put_data;
    logic [7:0]        ram_rdata;
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              out_free;

    assign len_word  = {shift_reg, byte_reg};
    assign sbl_after = (sbl_reg != '0) ? sbl_reg - PLEN_W'(1) : sbl_reg;
    assign len_bad   = (len_word == 32'd0) || (len_word > {8'd0, sbl_after})
                     || ((len_word >> LENGTH_BITS) != 32'd0);
    assign full      = count_reg >= CNT_W'(PARAM_STORE_BYTES);
    assign wr_en     = cmd.put && !full;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        case (cmd.put_sel)
            SEL_ZERO: put_data = 8'h00;
            SEL_ONE:  put_data = 8'h01;
            default:  put_data = byte_reg;
        endcase
    end

    always_comb begin
        out_byte  = 8'h00;
        out_valid = 1'b1;
        case (cmd.out_sel)
            SEL_BYTE: out_byte = byte_reg;
            SEL_ZERO: out_byte = 8'h00;
            SEL_ONE:  out_byte = 8'h01;
            SEL_RAM:  out_byte = ram_rdata;
            default:  out_valid = 1'b0;
        endcase
    end

    a2b_ram #(
        .WIDTH (8),
        .DEPTH (PARAM_STORE_BYTES)
    ) u_store (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (put_data),
        .re    (cmd.ram_rd),
        .raddr (pidx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ubl_reg      <= '0;
            units_reg    <= '0;
            sbl_reg      <= '0;
            nal_reg      <= '0;
            lencnt_reg   <= '0;
            dropped_reg  <= 1'b0;
            count_reg    <= '0;
            pidx_reg     <= '0;
            err_reg      <= STATUS_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.count_clr) begin
                count_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // first error of a record wins
            if (cmd.err_clr) begin
                err_reg <= STATUS_OK;
            end else if (cmd.err_set) begin
                err_reg <= STATUS_BAD_LEN;
            end else if (cmd.put && full && err_reg == STATUS_OK) begin
                err_reg <= STATUS_OVERFLOW;
            end

            if (cmd.rec_init) begin
                ubl_reg <= REC_HEAD_BYTES;
            end else if (cmd.ubl_dec) begin
                ubl_reg <= ubl_reg - 16'd1;
            end else if (cmd.ubl_hi) begin
                ubl_reg <= {byte_reg, 8'h00};
            end else if (cmd.ubl_lo) begin
                ubl_reg <= {ubl_reg[15:8], byte_reg};
            end

            if (cmd.rec_init) begin
                units_reg <= '0;
            end else if (cmd.units_load) begin
                units_reg <= byte_reg[4:0];
            end else if (cmd.units_dec) begin
                units_reg <= units_reg - 5'd1;
            end

            if (cmd.smp_init) begin
                sbl_reg <= plen_reg;
            end else if (cmd.sbl_dec) begin
                sbl_reg <= sbl_after;
            end

            if (cmd.smp_init) begin
                dropped_reg <= 1'b0;
            end else if (cmd.drop_load) begin
                dropped_reg <= st.type_sei;
            end

            if (cmd.len_clr) begin
                lencnt_reg <= '0;
            end else if (cmd.len_shift) begin
                lencnt_reg <= lencnt_reg + 2'd1;
            end

            if (cmd.nal_load) begin
                nal_reg <= len_word[NAL_W-1:0];
            end else if (cmd.nal_dec) begin
                nal_reg <= nal_reg - NAL_W'(1);
            end

            if (cmd.pidx_clr) begin
                pidx_reg <= '0;
            end else if (cmd.pidx_inc) begin
                pidx_reg <= pidx_reg + CNT_W'(1);
            end

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            plen_reg <= s_tdata[31:8];
            last_reg <= s_tlast;
        end
        if (cmd.len_shift) begin
            shift_reg <= {shift_reg[15:0], byte_reg};
        end
        if (cmd.out_load) begin
            m_tdata_reg <= out_byte;
            m_tuser_reg <= {cmd.out_status, cmd.out_run_last, out_valid};
            m_tlast_reg <= cmd.out_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        st.mode            = mode_reg;
        st.last            = last_reg;
        st.plen_lt4        = plen_reg < MIN_NAL_SPAN;
        st.ubl_one         = ubl_reg == 16'd1;
        st.ubl_zero        = ubl_reg == 16'd0;
        st.units_one       = units_reg == 5'd1;
        st.byte_units_zero = byte_reg[4:0] == 5'd0;
        st.sbl_dec_lt4     = sbl_after < MIN_NAL_SPAN;
        st.len_fourth      = lencnt_reg == 2'd3;
        st.len_bad         = len_bad;
        st.nal_one         = nal_reg == NAL_W'(1);
        st.type_idr        = byte_reg[4:0] == NAL_TYPE_IDR;
        st.type_sei        = byte_reg[4:0] == NAL_TYPE_SEI;
        st.dropped         = dropped_reg;
        st.err             = err_reg;
        st.pidx_end        = pidx_reg == count_reg;
        st.out_free        = out_free;
    end

`ifndef NO_ASSERTIONS
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ram_rd |-> (pidx_reg < count_reg))
        else $error("store read beyond filled entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PARAM_STORE_BYTES))
        else $error("store fill count past capacity");

    a_overflow_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && full) |=> (err_reg != STATUS_OK))
        else $error("store overflow not flagged");
`endif

endmodule

/* rtl/a2b_ctrl.sv */
// ----------------------------------------------------------------------------
// a2b_ctrl
// Controller: parse phase tracking and per-byte action sequencing.
// ----------------------------------------------------------------------------
module a2b_ctrl import a2b_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  a2b_stat_t st,
    output a2b_cmd_t  cmd
);

    typedef enum logic [3:0] {
        P_IDLE        = 4'd0,
        P_REC_HEAD    = 4'd1,
        P_REC_NSPS    = 4'd2,
        P_REC_SLEN_HI = 4'd3,
        P_REC_SLEN_LO = 4'd4,
        P_REC_SDATA   = 4'd5,
        P_REC_NPPS    = 4'd6,
        P_REC_PLEN_HI = 4'd7,
        P_REC_PLEN_LO = 4'd8,
        P_REC_PDATA   = 4'd9,
        P_REC_TAIL    = 4'd10,
        P_SMP_LEN     = 4'd11,
        P_SMP_HDR     = 4'd12,
        P_SMP_BODY    = 4'd13,
        P_SMP_TAIL    = 4'd14
    } phase_t;

    typedef enum logic [3:0] {
        C_WAIT,
        C_START,
        C_BYTE,
        C_PUT,
        C_PRD,
        C_POUT,
        C_SC,
        C_BOUT,
        C_FIN
    } state_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       s_tready_reg;

    logic       in_record;
    logic       pps;
    logic       tail;
    logic [1:0] close_status;
    phase_t     unit_done_phase;
    phase_t     boundary_phase;

    always_comb begin
        in_record = phase_reg inside {[P_REC_HEAD:P_REC_TAIL]};
        pps       = phase_reg >= P_REC_NPPS;
        tail      = st.mode ? (phase_reg == P_SMP_TAIL) : (phase_reg == P_REC_TAIL);

        if (st.err != STATUS_OK) begin
            close_status = st.err;
        end else if (tail) begin
            close_status = STATUS_OK;
        end else begin
            close_status = st.mode ? STATUS_BAD_LEN : STATUS_BAD_RECORD;
        end

        if (st.units_one) begin
            unit_done_phase = pps ? P_REC_TAIL : P_REC_NPPS;
        end else begin
            unit_done_phase = pps ? P_REC_PLEN_HI : P_REC_SLEN_HI;
        end

        // a remainder too short for a length field is dropped as tail
        boundary_phase = st.sbl_dec_lt4 ? P_SMP_TAIL : P_SMP_LEN;
    end

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        cmd.capture = s_tvalid && s_tready_reg;

        case (state_reg)
            C_WAIT: begin
                if (cmd.capture) begin
                    state_next = C_START;
                end
            end

            C_START: begin
                state_next = C_BYTE;
                if (!st.mode) begin
                    if (!in_record) begin
                        // first byte opens a record and is itself skipped
                        cmd.count_clr = 1'b1;
                        cmd.err_clr   = 1'b1;
                        cmd.rec_init  = 1'b1;
                        phase_next    = P_REC_HEAD;
                        state_next    = C_FIN;
                    end
                end else if (phase_reg < P_SMP_LEN) begin
                    cmd.count_clr = in_record;
                    cmd.err_clr   = 1'b1;
                    cmd.smp_init  = 1'b1;
                    cmd.len_clr   = 1'b1;
                    phase_next    = st.plen_lt4 ? P_SMP_TAIL : P_SMP_LEN;
                end
            end

            C_BYTE: begin
                state_next = C_FIN;
                if (!st.mode) begin
                    case (phase_reg)
                        P_REC_HEAD: begin
                            cmd.ubl_dec = 1'b1;
                            if (st.ubl_one) begin
                                phase_next = P_REC_NSPS;
                            end
                        end
                        P_REC_NSPS: begin
                            cmd.units_load = 1'b1;
                            phase_next = st.byte_units_zero ? P_REC_NPPS : P_REC_SLEN_HI;
                        end
                        P_REC_NPPS: begin
                            cmd.units_load = 1'b1;
                            phase_next = st.byte_units_zero ? P_REC_TAIL : P_REC_PLEN_HI;
                        end
                        P_REC_SLEN_HI: begin
                            cmd.ubl_hi = 1'b1;
                            phase_next = P_REC_SLEN_LO;
                        end
                        P_REC_PLEN_HI: begin
                            cmd.ubl_hi = 1'b1;
                            phase_next = P_REC_PLEN_LO;
                        end
                        P_REC_SLEN_LO, P_REC_PLEN_LO: begin
                            cmd.ubl_lo = 1'b1;
                            cnt_next   = 2'd0;
                            state_next = C_PUT;
                        end
                        P_REC_SDATA, P_REC_PDATA: begin
                            cmd.put     = 1'b1;
                            cmd.put_sel = SEL_BYTE;
                            cmd.ubl_dec = 1'b1;
                            if (st.ubl_one) begin
                                cmd.units_dec = 1'b1;
                                phase_next    = unit_done_phase;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    cmd.sbl_dec = 1'b1;
                    case (phase_reg)
                        P_SMP_LEN: begin
                            cmd.len_shift = 1'b1;
                            if (st.len_fourth) begin
                                if (st.len_bad) begin
                                    cmd.err_set = 1'b1;
                                    phase_next  = P_SMP_TAIL;
                                end else begin
                                    cmd.nal_load = 1'b1;
                                    phase_next   = P_SMP_HDR;
                                end
                            end
                        end
                        P_SMP_HDR: begin
                            cmd.drop_load = 1'b1;
                            cmd.nal_dec   = 1'b1;
                            if (st.nal_one) begin
                                cmd.len_clr = 1'b1;
                                phase_next  = boundary_phase;
                            end else begin
                                phase_next  = P_SMP_BODY;
                            end
                            if (!st.type_sei) begin
                                cmd.pidx_clr = 1'b1;
                                cnt_next     = 2'd0;
                                state_next   = st.type_idr ? C_PRD : C_SC;
                            end
                        end
                        P_SMP_BODY: begin
                            cmd.nal_dec = 1'b1;
                            if (st.nal_one) begin
                                cmd.len_clr = 1'b1;
                                phase_next  = boundary_phase;
                            end
                            if (!st.dropped) begin
                                state_next = C_BOUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            C_PUT: begin
                // 00 00 00 01 ahead of each stored unit
                cmd.put     = 1'b1;
                cmd.put_sel = (cnt_reg == 2'd3) ? SEL_ONE : SEL_ZERO;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = C_FIN;
                    if (st.ubl_zero) begin
                        cmd.units_dec = 1'b1;
                        phase_next    = unit_done_phase;
                    end else begin
                        phase_next = (phase_reg == P_REC_PLEN_LO) ? P_REC_PDATA : P_REC_SDATA;
                    end
                end
            end

            C_PRD: begin
                if (st.pidx_end) begin
                    cnt_next   = 2'd0;
                    state_next = C_SC;
                end else begin
                    cmd.ram_rd = 1'b1;
                    state_next = C_POUT;
                end
            end

            C_POUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_RAM;
                    cmd.pidx_inc = 1'b1;
                    state_next   = C_PRD;
                end
            end

            C_SC: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = (cnt_reg == 2'd2) ? SEL_ONE : SEL_ZERO;
                    cnt_next     = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        state_next = C_BOUT;
                    end
                end
            end

            C_BOUT: begin
                if (st.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = SEL_BYTE;
                    cmd.out_run_last = 1'b1;
                    cmd.out_end      = st.last;
                    cmd.out_status   = st.last ? close_status : STATUS_OK;
                    if (st.last) begin
                        cmd.err_clr = 1'b1;
                        phase_next  = P_IDLE;
                    end
                    state_next = C_WAIT;
                end
            end

            C_FIN: begin
                if (!st.last) begin
                    state_next = C_WAIT;
                end else if (st.out_free) begin
                    // bare marker closes a record, or a sample step without data
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = SEL_MARK;
                    cmd.out_run_last = 1'b1;
                    cmd.out_end      = 1'b1;
                    cmd.out_status   = close_status;
                    cmd.err_clr      = 1'b1;
                    cmd.count_clr    = !st.mode && (close_status != STATUS_OK);
                    phase_next       = P_IDLE;
                    state_next       = C_WAIT;
                end
            end

            default: begin
                state_next = C_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= C_WAIT;
            phase_reg    <= P_IDLE;
            cnt_reg      <= 2'd0;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            s_tready_reg <= (state_next == C_WAIT);
        end
    end

    assign s_tready = s_tready_reg;

`ifndef NO_ASSERTIONS
    a_put_in_record: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> !st.mode)
        else $error("store write outside record mode");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    a_close_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_end) |=> (phase_reg == P_IDLE))
        else $error("parse phase not idle after close");
`endif

endmodule

/* rtl/avcc_to_annexb_converter.sv */
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Byte-serial H.264 length-prefixed (avcC) to Annex B converter.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                        | tuser                        | tlast
//  s_ input | in  | [7:0] in_byte, [31:8] pkt len| mode (0 record, 1 sample)    | last_byte
//  m_ result| out | [7:0] out_byte               | [0] byte_valid, [1] run_last,| packet_end
//           |     |                              | [3:2] status                 |
//
// Each input byte is fully processed before the next is accepted. The low byte of a
// parameter set size writes a four-byte start code into the store one byte per
// cycle; an IDR header byte first sends every stored parameter byte (registered
// store read, then output register load). The controller sequences one action per
// cycle except where a stalled m_tready holds it at its next output load. Reset:
// synchronous, active low; the parameter set is empty after it.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter import a2b_pkg::*; #(
    parameter int PARAM_STORE_BYTES = 56,
    parameter int LENGTH_BITS       = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] in_byte, [31:8] packet_length
    input  logic                  s_tuser,   // [0] mode
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [OUT_USER_W-1:0] m_tuser,   // [0] byte_valid, [1] run_last, [3:2] status
    output logic                  m_tlast
);

    a2b_cmd_t  cmd;
    a2b_stat_t st;

    a2b_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    a2b_dp #(
        .PARAM_STORE_BYTES (PARAM_STORE_BYTES),
        .LENGTH_BITS       (LENGTH_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

/* tb/sv/tb_avcc_to_annexb_converter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_avcc_to_annexb_converter
// Self-checking bench for the avcC to Annex B converter. Configuration records
// and length-prefixed samples go in byte by byte; a scoreboard class tracks
// the parser state and the stored parameter sets, predicts every output
// transaction and compares it field by field. Both stream sides idle at random,
// and one long output stall backs the converter up into its input.
// ---------------------------------------------------------------------------
module tb_avcc_to_annexb_converter;
    import a2b_pkg::*;

    localparam int STORE_BYTES     = 56;
    localparam int LEN_BITS        = 24;
    localparam int MAX_RESULTS     = 60;
    localparam int LEN_FIELD_BYTES = 4;
    localparam int IDLE_PCT        = 22;
    localparam int ITEM_COUNT      = 370;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 300;

    localparam bit MODE_RECORD = 1'b0;
    localparam bit MODE_SAMPLE = 1'b1;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       pend;
        logic       rlast;
        logic [1:0] status;
    } annexb_beat_t;

    // Tracks the converter's parse state and the Annex B output it owes.
    class annexb_scoreboard;
        typedef enum int {
            PH_IDLE, PH_REC_HEAD, PH_REC_NSPS, PH_REC_SLEN_HI, PH_REC_SLEN_LO,
            PH_REC_SDATA, PH_REC_NPPS, PH_REC_PLEN_HI, PH_REC_PLEN_LO, PH_REC_PDATA,
            PH_REC_TAIL, PH_SMP_LEN, PH_SMP_HDR, PH_SMP_BODY, PH_SMP_TAIL
        } phase_t;

        phase_t       phase;
        logic [31:0]  len_acc;
        logic [31:0]  nal_left;
        logic [23:0]  smp_left;
        logic         drop_nal;
        logic [7:0]   pset [STORE_BYTES];
        int           pset_len;
        logic [4:0]   units;
        logic [15:0]  unit_left;
        logic [1:0]   err;
        annexb_beat_t step_q[$];
        annexb_beat_t owed_q[$];
        int           errors;
        int           checked;
        int           idr_inserts;

        function new();
            phase     = PH_IDLE;
            len_acc   = '0;
            nal_left  = '0;
            smp_left  = '0;
            drop_nal  = 1'b0;
            pset_len  = 0;
            units     = '0;
            unit_left = '0;
            err       = STATUS_OK;
            errors    = 0;
            checked   = 0;
            idr_inserts = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void add_beat(logic [7:0] d, logic v);
            annexb_beat_t bt;
            if (step_q.size() >= MAX_RESULTS) return;
            bt.data   = d;
            bt.valid  = v;
            bt.pend   = 1'b0;
            bt.rlast  = 1'b0;
            bt.status = STATUS_OK;
            step_q.push_back(bt);
        endfunction

        function void close_step(logic [1:0] st);
            annexb_beat_t bt;
            bt = step_q.pop_back();
            bt.pend   = 1'b1;
            bt.status = st;
            step_q.push_back(bt);
        endfunction

        function void put_param(logic [7:0] b);
            if (pset_len >= STORE_BYTES) begin
                if (err == STATUS_OK) err = STATUS_OVERFLOW;
                return;
            end
            pset[pset_len] = b;
            pset_len++;
        endfunction

        function void unit_finished(bit pps);
            units = units - 5'd1;
            if (units != 0) phase = pps ? PH_REC_PLEN_HI : PH_REC_SLEN_HI;
            else phase = pps ? PH_REC_TAIL : PH_REC_NPPS;
        endfunction

        function void record_byte(logic [7:0] b);
            bit pps;
            pps = (phase >= PH_REC_NPPS);
            case (phase)
                PH_REC_HEAD: begin
                    unit_left = unit_left - 16'd1;
                    if (unit_left == 0) phase = PH_REC_NSPS;
                end
                PH_REC_NSPS, PH_REC_NPPS: begin
                    units = b[4:0];
                    if (units == 0) phase = pps ? PH_REC_TAIL : PH_REC_NPPS;
                    else phase = pps ? PH_REC_PLEN_HI : PH_REC_SLEN_HI;
                end
                PH_REC_SLEN_HI, PH_REC_PLEN_HI: begin
                    unit_left = {b, 8'h00};
                    phase = pps ? PH_REC_PLEN_LO : PH_REC_SLEN_LO;
                end
                PH_REC_SLEN_LO, PH_REC_PLEN_LO: begin
                    unit_left[7:0] = b;
                    put_param(8'h00);
                    put_param(8'h00);
                    put_param(8'h00);
                    put_param(8'h01);
                    if (unit_left == 0) unit_finished(pps);
                    else phase = pps ? PH_REC_PDATA : PH_REC_SDATA;
                end
                PH_REC_SDATA, PH_REC_PDATA: begin
                    put_param(b);
                    unit_left = unit_left - 16'd1;
                    if (unit_left == 0) unit_finished(pps);
                end
                default: ;
            endcase
        endfunction

        function void nal_boundary();
            if (smp_left < MIN_NAL_SPAN) begin
                phase = PH_SMP_TAIL;
            end else begin
                phase    = PH_SMP_LEN;
                len_acc  = '0;
                nal_left = '0;
            end
        endfunction

        function void sample_byte(logic [7:0] b);
            if (smp_left != 0) smp_left = smp_left - 24'd1;
            case (phase)
                PH_SMP_LEN: begin
                    len_acc  = {len_acc[23:0], b};
                    nal_left = nal_left + 1;
                    if (nal_left >= LEN_FIELD_BYTES) begin
                        if (len_acc == 0 || len_acc > {8'h00, smp_left} ||
                            (len_acc >> LEN_BITS) != 0) begin
                            err   = STATUS_BAD_LEN;
                            phase = PH_SMP_TAIL;
                        end else begin
                            nal_left = len_acc;
                            phase    = PH_SMP_HDR;
                        end
                    end
                end
                PH_SMP_HDR: begin
                    drop_nal = (b[4:0] == NAL_TYPE_SEI);
                    if (!drop_nal) begin
                        if (b[4:0] == NAL_TYPE_IDR) begin
                            if (pset_len > 0) idr_inserts++;
                            for (int i = 0; i < pset_len; i++) add_beat(pset[i], 1'b1);
                        end
                        add_beat(8'h00, 1'b1);
                        add_beat(8'h00, 1'b1);
                        add_beat(8'h01, 1'b1);
                        add_beat(b, 1'b1);
                    end
                    nal_left = nal_left - 1;
                    if (nal_left == 0) nal_boundary();
                    else phase = PH_SMP_BODY;
                end
                PH_SMP_BODY: begin
                    if (!drop_nal) add_beat(b, 1'b1);
                    nal_left = nal_left - 1;
                    if (nal_left == 0) nal_boundary();
                end
                default: ;
            endcase
        endfunction

        // Called for each accepted input transaction.
        function void note_input(bit mode, logic [7:0] b, logic [23:0] plen, bit last);
            bit           in_rec;
            annexb_beat_t bt;
            in_rec = (phase >= PH_REC_HEAD && phase <= PH_REC_TAIL);
            step_q.delete();
            if (mode == MODE_RECORD) begin
                if (!in_rec) begin
                    pset_len  = 0;
                    err       = STATUS_OK;
                    units     = '0;
                    unit_left = REC_HEAD_BYTES;
                    phase     = PH_REC_HEAD;
                end else begin
                    record_byte(b);
                end
                if (last) begin
                    if (phase != PH_REC_TAIL && err == STATUS_OK) err = STATUS_BAD_RECORD;
                    if (err != STATUS_OK) pset_len = 0;
                    add_beat(8'h00, 1'b0);
                    close_step(err);
                    phase = PH_IDLE;
                    err   = STATUS_OK;
                end
            end else begin
                if (phase < PH_SMP_LEN) begin
                    // a sample byte inside a record abandons it
                    if (in_rec) pset_len = 0;
                    err      = STATUS_OK;
                    drop_nal = 1'b0;
                    smp_left = plen;
                    nal_boundary();
                end
                sample_byte(b);
                if (last) begin
                    if (phase != PH_SMP_TAIL && err == STATUS_OK) err = STATUS_BAD_LEN;
                    if (step_q.size() == 0) add_beat(8'h00, 1'b0);
                    close_step(err);
                    phase = PH_IDLE;
                    err   = STATUS_OK;
                end
            end
            if (step_q.size() > 0) begin
                bt = step_q.pop_back();
                bt.rlast = 1'b1;
                step_q.push_back(bt);
            end
            foreach (step_q[i]) owed_q.push_back(step_q[i]);
        endfunction

        function void check_result(logic [7:0] data, logic [3:0] user, logic pend);
            annexb_beat_t want;
            if (owed_q.size() == 0) begin
                $error("unexpected result: out_byte=%0h tuser=%0h packet_end=%0b",
                       data, user, pend);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (data !== want.data) begin
                $error("out_byte: expected %0h, got %0h", want.data, data);
                errors++;
            end
            if (user[0] !== want.valid) begin
                $error("byte_valid: expected %0b, got %0b", want.valid, user[0]);
                errors++;
            end
            if (user[1] !== want.rlast) begin
                $error("run_last: expected %0b, got %0b", want.rlast, user[1]);
                errors++;
            end
            if (user[3:2] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, user[3:2]);
                errors++;
            end
            if (pend !== want.pend) begin
                $error("packet_end: expected %0b, got %0b", want.pend, pend);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    annexb_scoreboard sb;
    logic [7:0]       pkt[$];
    bit               steady;
    bit               hold_req;
    bit               hold_done;
    int               bytes_sent;
    int               records_sent;
    int               samples_sent;

    avcc_to_annexb_converter #(
        .PARAM_STORE_BYTES(STORE_BYTES),
        .LENGTH_BITS      (LEN_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // ---- packet builders -------------------------------------------------

    function automatic void push_len32(logic [31:0] v);
        pkt.push_back(v[31:24]);
        pkt.push_back(v[23:16]);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic logic [4:0] random_kind();
        int         r;
        logic [4:0] k;
        r = $urandom_range(99);
        if (r < 15) return NAL_TYPE_IDR;
        if (r < 30) return NAL_TYPE_SEI;
        k = 5'($urandom);
        if (k == NAL_TYPE_IDR || k == NAL_TYPE_SEI) k = 5'd1;
        return k;
    endfunction

    function automatic void push_nal(logic [4:0] kind, int body);
        push_len32(32'(body + 1));
        pkt.push_back({3'($urandom), kind});
        repeat (body) pkt.push_back(8'($urandom));
    endfunction

    function automatic void make_sample(int nals, int max_body);
        repeat (nals) push_nal(random_kind(), $urandom_range(0, max_body));
    endfunction

    function automatic void push_unit(int size);
        pkt.push_back(8'(size >> 8));
        pkt.push_back(8'(size));
        repeat (size) pkt.push_back(8'($urandom));
    endfunction

    function automatic void make_record(int n_sps, int n_pps, int min_size, int max_size);
        repeat (5) pkt.push_back(8'($urandom));
        pkt.push_back({3'($urandom), 5'(n_sps)});
        repeat (n_sps) push_unit($urandom_range(min_size, max_size));
        pkt.push_back({3'($urandom), 5'(n_pps)});
        repeat (n_pps) push_unit($urandom_range(min_size, max_size));
    endfunction

    // ---- drivers ---------------------------------------------------------

    task automatic send_byte(bit mode, logic [7:0] b, logic [23:0] plen, bit last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, b};
        s_tuser  <= mode;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(mode, b, plen, last);
        bytes_sent++;
    endtask

    // packet_length only matters on the first byte; the rest carry noise
    task automatic send_packet(bit mode, logic [23:0] plen, bit close);
        for (int i = 0; i < pkt.size(); i++)
            send_byte(mode, pkt[i], (i == 0) ? plen : 24'($urandom),
                      close && (i == pkt.size() - 1));
        pkt.delete();
        if (mode == MODE_SAMPLE) samples_sent++;
        else records_sent++;
    endtask

    task automatic send_good_record();
        make_record($urandom_range(1, 2), $urandom_range(1, 2), 0, 6);
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom));
        send_packet(MODE_RECORD, 24'($urandom), 1'b1);
    endtask

    task automatic send_good_sample();
        make_sample($urandom_range(1, 4), 10);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
        send_packet(MODE_SAMPLE, 24'(pkt.size()), 1'b1);
    endtask

    task automatic run_directed();
        // one SPS, one PPS, a trailing byte that is ignored
        pkt = '{8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF, 8'hE1, 8'h00, 8'h02, 8'h67, 8'h42,
                8'h01, 8'h00, 8'h01, 8'h68, 8'hAA};
        send_packet(MODE_RECORD, 24'hFFFFFF, 1'b1);
        // IDR, SEI (dropped), plain slice, three-byte tail
        pkt = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02,
                8'h06, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h00};
        send_packet(MODE_SAMPLE, 24'd20, 1'b1);
        // zero NAL length
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
        send_packet(MODE_SAMPLE, 24'd5, 1'b1);
        // length not below 2^24
        pkt = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h21};
        send_packet(MODE_SAMPLE, 24'hFFFFFF, 1'b1);
        // length past the packet end
        pkt = '{8'h00, 8'h00, 8'h00, 8'h09, 8'h01, 8'h02};
        send_packet(MODE_SAMPLE, 24'd6, 1'b1);
        // sample ends inside a unit
        pkt = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h41, 8'h11, 8'h22};
        send_packet(MODE_SAMPLE, 24'd9, 1'b1);
        // record cut off at the PPS count: set is emptied
        pkt = '{8'h01, 8'h4D, 8'h40, 8'h1E, 8'hFF, 8'hE0};
        send_packet(MODE_RECORD, 24'd0, 1'b1);
        // IDR with an empty set
        pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h25};
        send_packet(MODE_SAMPLE, 24'd5, 1'b1);
        // fourteen empty units fill the store exactly, then the widest IDR burst
        make_record(14, 0, 0, 0);
        send_packet(MODE_RECORD, 24'd0, 1'b1);
        pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5};
        send_packet(MODE_SAMPLE, 24'd5, 1'b1);
        // one unit more overflows the store
        make_record(15, 0, 0, 0);
        send_packet(MODE_RECORD, 24'd0, 1'b1);
        // record abandoned by a sample, sample abandoned by a record
        pkt = '{8'h01, 8'h42, 8'h00};
        send_packet(MODE_RECORD, 24'd0, 1'b0);
        pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h77};
        send_packet(MODE_SAMPLE, 24'd6, 1'b0);
        send_good_record();
        // empty sample: only a bare marker
        pkt = '{8'hFF};
        send_packet(MODE_SAMPLE, 24'd0, 1'b1);
        // huge packet length, sample stops at a unit boundary
        pkt = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'hFF};
        send_packet(MODE_SAMPLE, 24'hFFFFFF, 1'b1);
    endtask

    task automatic random_record();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 80) begin
            send_good_record();
        end else if (r < 87) begin
            make_record($urandom_range(1, 2), $urandom_range(1, 2), 0, 6);
            n = $urandom_range(1, pkt.size() - 6);
            repeat (n) void'(pkt.pop_back());
            send_packet(MODE_RECORD, 24'($urandom), 1'b1);
        end else if (r < 93) begin
            make_record(2, 1, 20, 30);
            send_packet(MODE_RECORD, 24'($urandom), 1'b1);
        end else begin
            make_record(1, 1, 0, 6);
            n = $urandom_range(1, pkt.size() - 1);
            repeat (n) void'(pkt.pop_back());
            send_packet(MODE_RECORD, 24'($urandom), 1'b0);
            send_good_sample();
        end
    endtask

    task automatic random_sample();
        int          r;
        int          n;
        logic [23:0] plen;
        r = $urandom_range(99);
        if (r < 78) begin
            send_good_sample();
        end else if (r < 83) begin
            make_sample($urandom_range(2, 4), 10);
            send_packet(MODE_SAMPLE, 24'($urandom_range(0, pkt.size() - 1)), 1'b1);
        end else if (r < 88) begin
            make_sample($urandom_range(0, 2), 8);
            case ($urandom_range(2))
                0: push_len32(32'd0);
                1: push_len32({8'($urandom_range(1, 255)), 24'($urandom)});
                default: push_len32(32'($urandom_range(40, 200)));
            endcase
            repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
            send_packet(MODE_SAMPLE, 24'(pkt.size()), 1'b1);
        end else if (r < 93) begin
            make_sample($urandom_range(1, 3), 10);
            plen = 24'(pkt.size());
            n = $urandom_range(1, pkt.size() - 1);
            repeat (n) void'(pkt.pop_back());
            send_packet(MODE_SAMPLE, plen, 1'b1);
        end else if (r < 96) begin
            make_sample($urandom_range(1, 3), 10);
            send_packet(MODE_SAMPLE, 24'($urandom), 1'b1);
        end else begin
            make_sample($urandom_range(1, 2), 6);
            send_packet(MODE_SAMPLE, 24'(pkt.size()), 1'b0);
            send_good_record();
        end
    endtask

    // output side parks for a long while; the block fills and stalls its input
    task automatic run_pressure();
        hold_req = 1'b1;
        send_good_record();
        repeat (3) push_nal(NAL_TYPE_IDR, 8);
        send_packet(MODE_SAMPLE, 24'(pkt.size()), 1'b1);
    endtask

    // ---- output side -----------------------------------------------------

    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // watchdog: cycles without any transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_avcc_to_annexb_converter NOT OK");
        $finish;
    end

    // ---- main sequence ---------------------------------------------------

    initial begin
        int n;
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        steady   = 1'b0;
        hold_req = 1'b0;
        bytes_sent   = 0;
        records_sent = 0;
        samples_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        n = 0;
        while (bytes_sent < ITEM_COUNT) begin
            steady = (n >= 1 && n < 4);
            if (n == 0) run_pressure();
            else if ($urandom_range(3) == 0) random_record();
            else random_sample();
            n++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d records and %0d samples; %0d results checked,",
                 bytes_sent, records_sent, samples_sent, sb.checked);
        $display("%0d IDR units carried parameter sets, %0d mismatches.",
                 sb.idr_inserts, sb.errors);
        if (sb.errors == 0) $display("tb_avcc_to_annexb_converter OK");
        else $display("tb_avcc_to_annexb_converter NOT OK");
        $finish;
    end

endmodule
